### sv/sbsph_pkg.sv
// ----------------------------------------------------------------------------
// sbsph_pkg
// Shared types and constants for the spectrum bar smoother with peak hold.
// ----------------------------------------------------------------------------
package sbsph_pkg;

	// bin store geometry
	localparam int BIN_W = 6;
	localparam int BINS  = 64;
	localparam logic [BIN_W:0] BIN_LIMIT = (BIN_W+1)'(BINS);

	// field widths
	localparam int LVL_W = 16;
	localparam int AGE_W = 8;
	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	// stream widths, padded to whole bytes
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 48;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_RISE_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_GAIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_FRAMES = 2'd2;

	// register reset values (0.84 and 0.58 in Q0.16, 0.8 s at 30 frames/s)
	localparam logic [LVL_W-1:0] RISE_GAIN_RST   = 16'd55050;
	localparam logic [LVL_W-1:0] FALL_GAIN_RST   = 16'd38011;
	localparam logic [AGE_W-1:0] PEAK_FRAMES_RST = 8'd24;

	// front queue depth
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [LVL_W-1:0] rise_gain;
		logic [LVL_W-1:0] fall_gain;
		logic [AGE_W-1:0] peak_reset_frames;
	} cfg_t;

	// item as classified by the front part
	typedef struct packed {
		logic             ok;
		logic [BIN_W-1:0] bin;
		logic [LVL_W-1:0] level;
	} q_item_t;

	// per-bin stored state
	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [LVL_W-1:0] peak;
		logic [AGE_W-1:0] age;
	} bin_state_t;

endpackage

### sv/spectrum_bar_smoother_peak_hold_top.sv
// ----------------------------------------------------------------------------
// spectrum_bar_smoother_peak_hold_top
// Attack/release smoothing of spectrum bar levels per bin, with held peak
// and peak age in frames.
// ----------------------------------------------------------------------------
// channel   dir  width  contents (lowest bit up)
// s_*       in   24     bin[5:0], level_in[21:6], zero pad
// m_*       out  48     bin_out[5:0], smoothed[21:6], peak[37:22],
//                       hold_age[45:38], zero pad
// cfg_*     in   2+16   index 0 rise_gain, 1 fall_gain, 2 peak_reset_frames
//
// One item per cycle sustained while m_tready stays high; each result passes
// the queue, store read, multiply, update and output register in turn.
// The per-bin read-modify-write loop is closed by forwarding, so repeated
// bins need no bubbles. The bin store starts cleared through per-bin valid
// bits; no clearing pass. A stalled output fills the pipeline and then the
// two-entry input queue before s_tready drops.
// ----------------------------------------------------------------------------
module spectrum_bar_smoother_peak_hold_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sbsph_pkg::S_DATA_W-1:0]   s_tdata,   // bin, level_in
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sbsph_pkg::M_DATA_W-1:0]   m_tdata,   // bin_out, smoothed, peak, hold_age
	input  logic                             cfg_we,
	input  logic [sbsph_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sbsph_pkg::CFG_DATA_W-1:0] cfg_data
);

	sbsph_pkg::cfg_t    cfg_q;
	logic               item_valid;
	logic               item_take;
	sbsph_pkg::q_item_t item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_gain         <= sbsph_pkg::RISE_GAIN_RST;
			cfg_q.fall_gain         <= sbsph_pkg::FALL_GAIN_RST;
			cfg_q.peak_reset_frames <= sbsph_pkg::PEAK_FRAMES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sbsph_pkg::REG_RISE_GAIN:   cfg_q.rise_gain <= cfg_data;
				sbsph_pkg::REG_FALL_GAIN:   cfg_q.fall_gain <= cfg_data;
				sbsph_pkg::REG_PEAK_FRAMES:
					cfg_q.peak_reset_frames <= cfg_data[sbsph_pkg::AGE_W-1:0];
				default: ;
			endcase
		end
	end

	sbsph_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item)
	);

	sbsph_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

### sv/sbsph_front.sv
// ----------------------------------------------------------------------------
// sbsph_front
// Accepts input transfers, flags bins inside the store, queues them for the
// back part in a small fifo.
// ----------------------------------------------------------------------------
module sbsph_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sbsph_pkg::S_DATA_W-1:0] s_tdata,
	output logic                           item_valid,
	input  logic                           item_take,
	output sbsph_pkg::q_item_t             item
);

	sbsph_pkg::q_item_t          fifo_q [sbsph_pkg::QDEPTH];
	logic [sbsph_pkg::QAW-1:0]   wr_ptr_q;
	logic [sbsph_pkg::QAW-1:0]   rd_ptr_q;
	logic [sbsph_pkg::QAW:0]     cnt_q;
	sbsph_pkg::q_item_t          in_item;
	logic                        push;
	logic                        pop;

	// classify the incoming item
	always_comb begin
		in_item.bin   = s_tdata[sbsph_pkg::BIN_W-1:0];
		in_item.level = s_tdata[sbsph_pkg::BIN_W +: sbsph_pkg::LVL_W];
		in_item.ok    = ({1'b0, in_item.bin} < sbsph_pkg::BIN_LIMIT);
	end

	assign s_tready   = (cnt_q != (sbsph_pkg::QAW+1)'(sbsph_pkg::QDEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = fifo_q[rd_ptr_q];
	assign push       = s_tvalid && s_tready;
	assign pop        = item_valid && item_take;

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= in_item;
	end

endmodule

### sv/sbsph_back.sv
// ----------------------------------------------------------------------------
// sbsph_back
// Per-bin read-modify-write pipeline: state read, attack/release multiply,
// level and peak update with write-back, output register.
// ----------------------------------------------------------------------------
module sbsph_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sbsph_pkg::cfg_t                cfg,
	input  logic                           item_valid,
	output logic                           item_take,
	input  sbsph_pkg::q_item_t             item,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sbsph_pkg::M_DATA_W-1:0] m_tdata
);

	// bin state store with one valid bit per bin
	sbsph_pkg::bin_state_t            mem_q [sbsph_pkg::BINS];
	logic [sbsph_pkg::BINS-1:0]       vld_q;

	// stage 1: read data and item
	logic                             valid_s1;
	logic                             ok_s1;
	logic [sbsph_pkg::BIN_W-1:0]      bin_s1;
	logic [sbsph_pkg::LVL_W-1:0]      target_s1;
	sbsph_pkg::bin_state_t            rd_s1;
	logic                             rdv_s1;

	// stage 2: product and current state
	logic                             valid_s2;
	logic                             ok_s2;
	logic [sbsph_pkg::BIN_W-1:0]      bin_s2;
	logic signed [33:0]               prod_s2;
	sbsph_pkg::bin_state_t            st_s2;

	// last write-back, for forwarding
	logic                             wb_valid_q;
	logic [sbsph_pkg::BIN_W-1:0]      wb_bin_q;
	sbsph_pkg::bin_state_t            wb_st_q;

	// output register
	logic                             out_valid_q;
	logic [sbsph_pkg::M_DATA_W-1:0]   out_data_q;

	logic                             out_free;
	logic                             s2_free;
	logic                             s1_free;
	logic                             adv_s2;
	sbsph_pkg::bin_state_t            cur_s1;
	logic signed [16:0]               diff_s1;
	logic [sbsph_pkg::LVL_W-1:0]      gain_s1;
	logic signed [33:0]               prod_s1;
	logic signed [17:0]               step_s2;
	logic signed [17:0]               sum_s2;
	logic [sbsph_pkg::LVL_W-1:0]      lvl_s2;
	logic [sbsph_pkg::AGE_W-1:0]      age_inc_s2;
	sbsph_pkg::bin_state_t            new_s2;

	// flow control
	assign out_free  = !out_valid_q || m_tready;
	assign s2_free   = !valid_s2 || out_free;
	assign adv_s2    = valid_s2 && out_free;
	assign s1_free   = !valid_s1 || s2_free;
	assign item_take = s1_free;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// stage 1: forward pending writes, then diff, gain and multiply
	always_comb begin
		if (valid_s2 && ok_s2 && (bin_s2 == bin_s1))
			cur_s1 = new_s2;
		else if (wb_valid_q && (wb_bin_q == bin_s1))
			cur_s1 = wb_st_q;
		else if (rdv_s1)
			cur_s1 = rd_s1;
		else
			cur_s1 = '0;
		diff_s1 = $signed({1'b0, target_s1}) - $signed({1'b0, cur_s1.level});
		gain_s1 = (diff_s1 > 17'sd0) ? cfg.rise_gain : cfg.fall_gain;
		prod_s1 = diff_s1 * $signed({1'b0, gain_s1});
	end

	// stage 2: level step with floor shift, clamp, peak hold
	always_comb begin
		step_s2 = prod_s2[33:16];
		sum_s2  = $signed({2'b00, st_s2.level}) + step_s2;
		if (sum_s2 < 18'sd0)
			lvl_s2 = '0;
		else if (sum_s2[17:16] != 2'b00)
			lvl_s2 = '1;
		else
			lvl_s2 = sum_s2[sbsph_pkg::LVL_W-1:0];
		age_inc_s2 = (st_s2.age == sbsph_pkg::AGE_MAX) ? st_s2.age : st_s2.age + 1'b1;
		new_s2.level = lvl_s2;
		if (lvl_s2 > st_s2.peak || age_inc_s2 > cfg.peak_reset_frames) begin
			new_s2.peak = lvl_s2;
			new_s2.age  = '0;
		end else begin
			new_s2.peak = st_s2.peak;
			new_s2.age  = age_inc_s2;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			wb_valid_q  <= 1'b0;
			vld_q       <= '0;
		end else begin
			if (s1_free)
				valid_s1 <= item_valid;
			if (s2_free)
				valid_s2 <= valid_s1;
			if (out_free)
				out_valid_q <= valid_s2;
			if (adv_s2 && ok_s2) begin
				wb_valid_q     <= 1'b1;
				vld_q[bin_s2]  <= 1'b1;
			end
		end
	end

	// payload, store read and write-back
	always_ff @(posedge clk) begin
		if (s1_free) begin
			ok_s1     <= item.ok;
			bin_s1    <= item.bin;
			target_s1 <= item.level;
			rd_s1     <= mem_q[item.bin];
			rdv_s1    <= vld_q[item.bin];
		end
		if (s2_free) begin
			ok_s2   <= ok_s1;
			bin_s2  <= bin_s1;
			prod_s2 <= prod_s1;
			st_s2   <= cur_s1;
		end
		if (adv_s2) begin
			if (ok_s2) begin
				mem_q[bin_s2] <= new_s2;
				wb_bin_q      <= bin_s2;
				wb_st_q       <= new_s2;
				out_data_q    <= {2'b00, new_s2.age, new_s2.peak, new_s2.level, bin_s2};
			end else begin
				out_data_q    <= {{(sbsph_pkg::M_DATA_W-sbsph_pkg::BIN_W){1'b0}}, bin_s2};
			end
		end
	end

endmodule
